// ===== rtl/core/stream_search_replace_unit_assert.svh =====
// assertion macros shared by the search and replace core
// expects clk and rst_n in the scope of the including module
`ifndef STREAM_SEARCH_REPLACE_UNIT_ASSERT_SVH
`define STREAM_SEARCH_REPLACE_UNIT_ASSERT_SVH

// property that holds at every edge outside reset
`define SSR_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition at one edge implies the expectation at the next edge
`define SSR_CHECK_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== rtl/core/ssr_pkg.sv =====
// shared constants, register codes and helpers of the search and replace core
// no dependencies
`default_nettype none

package ssr_pkg;

    localparam int DEF_MAX_SEARCH  = 8;
    localparam int DEF_MAX_REPLACE = 8;
    localparam int DEF_CHAR_BITS   = 16;

    localparam int PORT_CHAR_BITS = 16;
    localparam int SLOT_BITS      = 16;
    localparam int NUM_SLOTS      = 8;
    localparam int LEN_BITS       = 4;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH_LEN  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH_LOW  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH_HIGH = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPLACE_LEN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPLACE_LOW = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPLACE_HIGH = 3'd5;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] text_high;
        logic [CFG_DATA_BITS-1:0] text_low;
    } repl_text_t;

    // character slot of a two-word text; slots past the eighth read as zero
    function automatic logic [SLOT_BITS-1:0] slot_char(
        input logic [CFG_DATA_BITS-1:0] lo,
        input logic [CFG_DATA_BITS-1:0] hi,
        input int unsigned idx
    );
        logic [2*CFG_DATA_BITS-1:0] word;
        word = {hi, lo};
        if (idx < NUM_SLOTS)
        begin
            return word[idx*SLOT_BITS +: SLOT_BITS];
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssr_front.sv =====
// front end: configuration registers, pending window and pattern compare
// emits one command per item that has results; uses ssr_pkg
`default_nettype none

module ssr_front
    import ssr_pkg::*;
#(
    parameter int MAX_SEARCH  = DEF_MAX_SEARCH,
    parameter int MAX_REPLACE = DEF_MAX_REPLACE,
    parameter int CHAR_BITS   = DEF_CHAR_BITS,
    parameter type cmd_t      = logic
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [PORT_CHAR_BITS-1:0] s_tdata,
    input  wire logic                      s_tlast,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                           cmd_valid,
    input  wire logic                      cmd_ready,
    output cmd_t                           cmd,
    output repl_text_t                     repl
);

    localparam int CW = $clog2(MAX_SEARCH + 1);
    localparam int NW = $clog2(MAX_SEARCH + MAX_REPLACE + 1);
    localparam int RW = (MAX_REPLACE > 0) ? $clog2(MAX_REPLACE + 1) : 1;

    logic [LEN_BITS-1:0]      slen_reg;
    logic [CFG_DATA_BITS-1:0] stext_lo_reg;
    logic [CFG_DATA_BITS-1:0] stext_hi_reg;
    logic [LEN_BITS-1:0]      rlen_reg;
    logic [CFG_DATA_BITS-1:0] rtext_lo_reg;
    logic [CFG_DATA_BITS-1:0] rtext_hi_reg;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    logic [CHAR_BITS-1:0]     win_reg [MAX_SEARCH];

    logic                     s_acc;
    logic                     cfg_acc;
    logic [CHAR_BITS-1:0]     ch;
    logic [CW-1:0]            slen_c;
    logic [RW-1:0]            rlen_c;
    logic [CW-1:0]            cnt_eff;
    logic [CW-1:0]            cnt_inc;
    logic [CW-1:0]            cnt_after;
    logic [CHAR_BITS-1:0]     win_ins   [MAX_SEARCH];
    logic [CHAR_BITS-1:0]     win_after [MAX_SEARCH];
    logic [MAX_SEARCH-1:0]    pat_ok;
    logic                     full;
    logic                     match;
    logic [RW-1:0]            repl_n;
    logic                     has_one;
    logic [CW-1:0]            flush_n;
    logic [NW-1:0]            total;
    logic                     marker;
    logic                     push;

    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_tready  = cmd_ready;
    assign cfg_ready = 1'b1;
    assign ch        = CHAR_BITS'(s_tdata);

    always_comb
    begin
        if (slen_reg > LEN_BITS'(MAX_SEARCH > 15 ? 15 : MAX_SEARCH))
        begin
            slen_c = CW'(MAX_SEARCH);
        end
        else
        begin
            slen_c = CW'(slen_reg);
        end
        if (MAX_REPLACE < 15 && rlen_reg > LEN_BITS'(MAX_REPLACE < 15 ? MAX_REPLACE : 15))
        begin
            rlen_c = RW'(MAX_REPLACE);
        end
        else
        begin
            rlen_c = RW'(rlen_reg);
        end
    end

    always_comb
    begin
        cnt_eff = (cnt_reg >= CW'(MAX_SEARCH)) ? '0 : cnt_reg;
        cnt_inc = cnt_eff + 1'b1;
        for (int i = 0; i < MAX_SEARCH; i++)
        begin
            win_ins[i] = (cnt_eff == CW'(i)) ? ch : win_reg[i];
            pat_ok[i]  = (CW'(i) >= slen_c)
                      || (win_ins[i] == CHAR_BITS'(slot_char(stext_lo_reg, stext_hi_reg, i)));
        end
        match = &pat_ok;
        full  = (cnt_inc >= slen_c);

        repl_n    = '0;
        has_one   = 1'b0;
        cnt_after = cnt_inc;
        win_after = win_ins;
        if (full && match)
        begin
            repl_n    = rlen_c;
            cnt_after = '0;
        end
        else if (full)
        begin
            // oldest character leaves, the rest move down one place
            has_one   = 1'b1;
            cnt_after = cnt_inc - 1'b1;
            for (int i = 0; i < MAX_SEARCH - 1; i++)
            begin
                win_after[i] = win_ins[i+1];
            end
        end

        flush_n = s_tlast ? cnt_after : '0;
        total   = NW'(repl_n) + NW'(has_one) + NW'(flush_n);
        marker  = s_tlast && (total == '0);

        cmd         = '0;
        cmd.last    = s_tlast;
        cmd.has_one = has_one;
        cmd.repl_n  = repl_n;
        cmd.marker  = marker;
        cmd.total   = marker ? NW'(1) : total;
        cmd.one_char = win_ins[0];
        for (int i = 0; i < MAX_SEARCH; i++)
        begin
            cmd.win[i] = win_after[i];
        end

        if (slen_c == '0)
        begin
            // empty pattern: only the final character reports, as an error
            cmd        = '0;
            cmd.err    = 1'b1;
            cmd.last   = 1'b1;
            cmd.total  = NW'(1);
            push       = s_tlast;
            cnt_next   = '0;
        end
        else
        begin
            push     = s_tlast || (total != '0);
            cnt_next = s_tlast ? '0 : cnt_after;
        end
    end

    assign cmd_valid = s_acc && push;
    assign repl      = '{text_high: rtext_hi_reg, text_low: rtext_lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slen_reg     <= LEN_BITS'(1);
            stext_lo_reg <= '0;
            stext_hi_reg <= '0;
            rlen_reg     <= '0;
            rtext_lo_reg <= '0;
            rtext_hi_reg <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            // a new pattern length drops the pending characters
            if (cfg_acc && (cfg_index == REG_SEARCH_LEN))
            begin
                cnt_reg <= '0;
            end
            else if (s_acc)
            begin
                cnt_reg <= cnt_next;
            end
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    REG_SEARCH_LEN:   slen_reg     <= cfg_data[LEN_BITS-1:0];
                    REG_SEARCH_LOW:   stext_lo_reg <= cfg_data;
                    REG_SEARCH_HIGH:  stext_hi_reg <= cfg_data;
                    REG_REPLACE_LEN:  rlen_reg     <= cfg_data[LEN_BITS-1:0];
                    REG_REPLACE_LOW:  rtext_lo_reg <= cfg_data;
                    REG_REPLACE_HIGH: rtext_hi_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            for (int i = 0; i < MAX_SEARCH; i++)
            begin
                win_reg[i] <= win_after[i];
            end
        end
    end

`include "stream_search_replace_unit_assert.svh"

    `SSR_CHECK(a_cnt_below_max, cnt_reg < CW'(MAX_SEARCH), "pending count out of range")
    `SSR_CHECK_NEXT(a_last_clears, s_acc && s_tlast, cnt_reg == '0, "window kept after end")

endmodule

`default_nettype wire

// ===== rtl/core/ssr_cmd_fifo.sv =====
// two-entry command queue between the front and back ends
// uses ssr_pkg for its depth
`default_nettype none

module ssr_cmd_fifo
    import ssr_pkg::*;
#(
    parameter type cmd_t = logic
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      not_full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      not_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign not_full  = (cnt_reg != CNTW'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

`include "stream_search_replace_unit_assert.svh"

    `SSR_CHECK(a_no_push_when_full, push |-> not_full, "command pushed into a full queue")

endmodule

`default_nettype wire

// ===== rtl/core/ssr_back.sv =====
// back end: expands one command into result transactions, one per cycle while the master side takes them
// output register toward the master side; uses ssr_pkg
`default_nettype none

module ssr_back
    import ssr_pkg::*;
#(
    parameter int MAX_SEARCH  = DEF_MAX_SEARCH,
    parameter int MAX_REPLACE = DEF_MAX_REPLACE,
    parameter int CHAR_BITS   = DEF_CHAR_BITS,
    parameter type cmd_t      = logic
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    input  wire cmd_t                       cmd,
    output logic                            cmd_pop,
    input  wire repl_text_t                 repl,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [PORT_CHAR_BITS-1:0]       m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    localparam int NW = $clog2(MAX_SEARCH + MAX_REPLACE + 1);

    logic [NW-1:0]        pos_reg;
    logic                 m_valid_reg;
    logic [CHAR_BITS-1:0] char_reg;
    logic                 cv_reg;
    logic                 err_reg;
    logic                 last_reg;

    logic                 load;
    logic                 final_res;
    logic [NW-1:0]        flush_idx;
    logic [CHAR_BITS-1:0] res_char;
    logic                 res_cv;

    assign load      = cmd_valid && (!m_valid_reg || m_tready);
    assign final_res = (pos_reg == cmd.total - 1'b1);
    assign cmd_pop   = load && final_res;
    assign flush_idx = pos_reg - NW'(cmd.repl_n) - NW'(cmd.has_one);

    // replacement characters first, then the oldest character, then the flush; no character on error or marker
    always_comb
    begin
        res_char = '0;
        res_cv   = 1'b1;
        if (cmd.err || cmd.marker)
        begin
            res_cv = 1'b0;
        end
        else if (pos_reg < NW'(cmd.repl_n))
        begin
            res_char = CHAR_BITS'(slot_char(repl.text_low, repl.text_high, 32'(pos_reg)));
        end
        else if (cmd.has_one && (pos_reg == NW'(cmd.repl_n)))
        begin
            res_char = cmd.one_char;
        end
        else
        begin
            for (int i = 0; i < MAX_SEARCH; i++)
            begin
                if (flush_idx == NW'(i))
                begin
                    res_char = cmd.win[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pos_reg     <= final_res ? '0 : pos_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= res_char;
            cv_reg   <= res_cv;
            err_reg  <= cmd.err;
            last_reg <= cmd.last && final_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = PORT_CHAR_BITS'(char_reg);
    assign m_tuser  = {err_reg, cv_reg};
    assign m_tlast  = last_reg;

`include "stream_search_replace_unit_assert.svh"

    `SSR_CHECK(a_pos_in_cmd, cmd_valid |-> (pos_reg < cmd.total), "result index past command")
    `SSR_CHECK(a_err_is_last, (m_valid_reg && err_reg) |-> last_reg, "error result not last")

endmodule

`default_nettype wire

// ===== rtl/core/stream_search_replace_unit.sv =====
// path: the first result of an item is written into the command queue and then into the output
//   register before it is offered on the master side
// throughput: one subject character per cycle while the command queue has room; the back
//   end gives one result per cycle while the master side takes them
// reset: registers take their reset values, window empty, queue and output register empty
// top level of the search and replace core; joins front, command queue and back
`default_nettype none

module stream_search_replace_unit
    import ssr_pkg::*;
#(
    parameter int MAX_SEARCH  = DEF_MAX_SEARCH,
    parameter int MAX_REPLACE = DEF_MAX_REPLACE,
    parameter int CHAR_BITS   = DEF_CHAR_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [PORT_CHAR_BITS-1:0] s_tdata,   // subject_char
    input  wire logic                      s_tlast,   // subject_end
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [PORT_CHAR_BITS-1:0]      m_tdata,   // out_char
    output logic [1:0]                     m_tuser,   // char_valid, error
    output logic                           m_tlast,   // out_last
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int NW = $clog2(MAX_SEARCH + MAX_REPLACE + 1);
    localparam int RW = (MAX_REPLACE > 0) ? $clog2(MAX_REPLACE + 1) : 1;

    typedef struct packed {
        logic                                  err;
        logic                                  marker;
        logic                                  last;
        logic                                  has_one;
        logic [RW-1:0]                         repl_n;
        logic [NW-1:0]                         total;
        logic [CHAR_BITS-1:0]                  one_char;
        logic [MAX_SEARCH-1:0][CHAR_BITS-1:0]  win;
    } cmd_t;

    cmd_t       push_cmd;
    cmd_t       head_cmd;
    logic       push_valid;
    logic       q_not_full;
    logic       q_not_empty;
    logic       q_pop;
    repl_text_t repl;

    ssr_front #(
        .MAX_SEARCH  (MAX_SEARCH),
        .MAX_REPLACE (MAX_REPLACE),
        .CHAR_BITS   (CHAR_BITS),
        .cmd_t       (cmd_t)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (push_valid),
        .cmd_ready (q_not_full),
        .cmd       (push_cmd),
        .repl      (repl)
    );

    ssr_cmd_fifo #(
        .cmd_t (cmd_t)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .head      (head_cmd),
        .not_empty (q_not_empty)
    );

    ssr_back #(
        .MAX_SEARCH  (MAX_SEARCH),
        .MAX_REPLACE (MAX_REPLACE),
        .CHAR_BITS   (CHAR_BITS),
        .cmd_t       (cmd_t)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .repl      (repl),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/stream_search_replace_unit_tb.sv =====
// testbench of stream_search_replace_unit: streams subject text into the unit and checks
// every output transaction against a behavioral search and replace predictor
// depends on ssr_pkg and the rtl of stream_search_replace_unit

module stream_search_replace_unit_tb;
    import ssr_pkg::*;

    typedef struct {
        logic [15:0] ch;
        logic        last;
    } subj_item_t;

    typedef struct {
        logic [15:0] ch;
        logic        valid;
        logic        last;
        logic        err;
    } text_out_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [15:0]              s_tdata;
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [15:0]              m_tdata;
    logic [1:0]               m_tuser;
    logic                     m_tlast;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // predictor copy of the registers and the pending window
    logic [3:0]  pat_len;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [3:0]  rep_len;
    logic [63:0] rep_lo;
    logic [63:0] rep_hi;
    logic [15:0] pend [0:7];
    int          pend_cnt;

    subj_item_t  subject_q [$];
    text_out_t   expected_text_q [$];

    logic [15:0] alpha_base;
    bit          in_took = 1'b0;
    bit          hold_go = 1'b0;
    int          gap_left = 0;
    int          burst_left = 1;
    int          stall_mode = 0;
    int          stall_run = 0;
    int          errors = 0;
    int          chars_in = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    int          phases = 0;

    stream_search_replace_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    // long receiver hold-off, counted here so the stimulus keeps feeding meanwhile
    initial
    begin
        wait (hold_go == 1'b1);
        repeat (300) @(posedge clk);
        hold_go = 1'b0;
    end

    function automatic logic [15:0] text_slot(input logic [63:0] lo, input logic [63:0] hi,
                                              input int idx);
        logic [127:0] both;
        both = {hi, lo};
        return both[idx*16 +: 16];
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("mismatch at result %0d: %s expected %h got %h", results_seen, what, want, got);
        errors++;
    endtask

    // one subject character through the predictor; results go to the expected store
    task automatic search_replace_step(input logic [15:0] ch, input logic last);
        text_out_t res [0:15];
        int        n;
        int        slen;
        int        rlen;
        int        i;
        logic      hit;
        n = 0;
        slen = (pat_len > 8) ? 8 : int'(pat_len);
        rlen = (rep_len > 8) ? 8 : int'(rep_len);
        if (slen == 0)
        begin
            pend_cnt = 0;
            if (last)
                expected_text_q.push_back('{16'h0000, 1'b0, 1'b1, 1'b1});
        end
        else
        begin
            pend[pend_cnt] = ch;
            pend_cnt++;
            if (pend_cnt >= slen)
            begin
                hit = 1'b1;
                for (i = 0; i < slen; i++)
                    if (pend[i] != text_slot(pat_lo, pat_hi, i))
                        hit = 1'b0;
                if (hit)
                begin
                    for (i = 0; i < rlen; i++)
                    begin
                        res[n] = '{text_slot(rep_lo, rep_hi, i), 1'b1, 1'b0, 1'b0};
                        n++;
                    end
                    pend_cnt = 0;
                end
                else
                begin
                    res[n] = '{pend[0], 1'b1, 1'b0, 1'b0};
                    n++;
                    for (i = 1; i < pend_cnt; i++)
                        pend[i-1] = pend[i];
                    pend_cnt--;
                end
            end
            if (last)
            begin
                for (i = 0; i < pend_cnt; i++)
                begin
                    res[n] = '{pend[i], 1'b1, 1'b0, 1'b0};
                    n++;
                end
                pend_cnt = 0;
                if (n == 0)
                begin
                    res[0] = '{16'h0000, 1'b0, 1'b0, 1'b0};
                    n = 1;
                end
                res[n-1].last = 1'b1;
            end
            for (i = 0; i < n; i++)
                expected_text_q.push_back(res[i]);
        end
    endtask

    // input side: bursts of random length with random gaps, valid held until taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_took))
        begin
            in_took = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (subject_q.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= subject_q[0].ch;
                s_tlast  <= subject_q[0].last;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side: stall pattern switches between modes after runs of random length
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(16, 96);
        end
        else
            stall_run--;
        if (hold_go)
            m_tready <= 1'b0;
        else
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 4) != 0);
                default: m_tready <= ~m_tready;
            endcase
    end

    always @(posedge clk)
    begin : monitor
        subj_item_t took;
        text_out_t  want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                took = subject_q.pop_front();
                search_replace_step(took.ch, took.last);
                chars_in++;
                in_took = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_text_q.size() == 0)
                    report_mismatch("result with nothing expected, out_char", 16'h0, m_tdata);
                else
                begin
                    want = expected_text_q.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch("out_char", want.ch, m_tdata);
                    if (m_tuser[0] !== want.valid)
                        report_mismatch("char_valid", want.valid, m_tuser[0]);
                    if (m_tlast !== want.last)
                        report_mismatch("out_last", want.last, m_tlast);
                    if (m_tuser[1] !== want.err)
                        report_mismatch("error", want.err, m_tuser[1]);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SEARCH_LEN:
            begin
                pat_len = val[3:0];
                pend_cnt = 0;
            end
            REG_SEARCH_LOW:   pat_lo = val;
            REG_SEARCH_HIGH:  pat_hi = val;
            REG_REPLACE_LEN:  rep_len = val[3:0];
            REG_REPLACE_LOW:  rep_lo = val;
            REG_REPLACE_HIGH: rep_hi = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_subject(input logic [15:0] ch, input logic last);
        subject_q.push_back('{ch, last});
    endtask

    // wait until all input is taken and every expected result is back, then settle
    task automatic wait_idle();
        int spin;
        spin = 0;
        while (subject_q.size() != 0)
            @(posedge clk);
        while (expected_text_q.size() != 0 && spin < 20000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (8) @(posedge clk);
        while (expected_text_q.size() != 0)
        begin
            report_mismatch("result never arrived, out_char", expected_text_q[0].ch, 16'hxxxx);
            void'(expected_text_q.pop_front());
        end
    endtask

    // random subject text: pattern copies, broken prefixes, alphabet characters and some noise
    task automatic queue_subject(input int len, input bit finish);
        logic [15:0] txt [0:63];
        int          n;
        int          slen;
        int          k;
        int          i;
        int          r;
        slen = (pat_len > 8) ? 8 : int'(pat_len);
        n = 0;
        while (n < len)
        begin
            r = $urandom_range(0, 9);
            if (slen != 0 && r < 4)
            begin
                for (i = 0; i < slen && n < len; i++)
                begin
                    txt[n] = text_slot(pat_lo, pat_hi, i);
                    n++;
                end
            end
            else if (slen > 1 && r < 6)
            begin
                k = $urandom_range(1, slen - 1);
                for (i = 0; i < k && n < len; i++)
                begin
                    txt[n] = text_slot(pat_lo, pat_hi, i);
                    n++;
                end
                if (n < len)
                begin
                    txt[n] = alpha_base + 16'($urandom_range(0, 3));
                    n++;
                end
            end
            else if (r < 9)
            begin
                txt[n] = alpha_base + 16'($urandom_range(0, 3));
                n++;
            end
            else
            begin
                txt[n] = 16'($urandom);
                n++;
            end
        end
        for (i = 0; i < len; i++)
            subject_q.push_back('{txt[i], finish && (i == len - 1)});
    endtask

    task automatic random_setup(input int ph, input bit keep_text);
        logic [127:0] word;
        int           i;
        int           slen;
        int           rlen;
        alpha_base = ($urandom_range(0, 9) < 7) ? 16'h0061 : 16'($urandom_range(0, 65532));
        if (ph == 0)
            slen = 1;
        else if (ph == 1)
            slen = 8;
        else if (ph != 2 && $urandom_range(0, 9) == 0)
            slen = 0;
        else if ($urandom_range(0, 9) == 0)
            slen = $urandom_range(9, 15);
        else
            slen = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 8);
        if (ph == 0)
            rlen = 0;
        else if (ph == 1)
            rlen = 8;
        else
            rlen = $urandom_range(0, 15);
        for (i = 0; i < 8; i++)
            word[i*16 +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : alpha_base
                                                              + 16'($urandom_range(0, 3));
        if (!keep_text)
            write_reg(REG_SEARCH_LEN, 64'(slen));
        write_reg(REG_SEARCH_LOW, word[63:0]);
        write_reg(REG_SEARCH_HIGH, word[127:64]);
        write_reg(REG_REPLACE_LEN, 64'(rlen));
        write_reg(REG_REPLACE_LOW, {$urandom, $urandom});
        write_reg(REG_REPLACE_HIGH, {$urandom, $urandom});
    endtask

    initial
    begin : stimulus
        int  ph;
        int  i;
        int  target;
        int  pushed;
        int  len;
        int  rand_items;
        bit  finish;
        bit  open_text;
        bit  paused;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pat_len   = 4'd1;
        pat_lo    = '0;
        pat_hi    = '0;
        rep_len   = 4'd0;
        rep_lo    = '0;
        rep_hi    = '0;
        pend_cnt  = 0;
        for (i = 0; i < 8; i++)
            pend[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: single zero pattern deleted, end marker when nothing is left
        push_subject(16'h0000, 1'b0);
        push_subject(16'hFFFF, 1'b0);
        push_subject(16'h0000, 1'b1);
        wait_idle();

        // empty pattern
        write_reg(REG_SEARCH_LEN, 64'd0);
        push_subject(16'h1234, 1'b0);
        push_subject(16'hFFFF, 1'b1);
        wait_idle();

        // three-character pattern, full-length replacement with extreme characters
        write_reg(REG_SEARCH_LEN, 64'd3);
        write_reg(REG_SEARCH_LOW, {16'h0000, 16'h0043, 16'h0042, 16'h0041});
        write_reg(REG_REPLACE_LEN, 64'd8);
        write_reg(REG_REPLACE_LOW, {16'h0001, 16'h8000, 16'h0000, 16'hFFFF});
        write_reg(REG_REPLACE_HIGH, {16'h7FFF, 16'hAAAA, 16'h5555, 16'h1234});
        push_subject(16'h0041, 1'b0);
        push_subject(16'h0042, 1'b0);
        push_subject(16'h0043, 1'b0);
        push_subject(16'h0041, 1'b0);
        push_subject(16'h0042, 1'b1);
        wait_idle();

        // pattern text changed while characters are pending
        push_subject(16'h0041, 1'b0);
        push_subject(16'h0042, 1'b0);
        wait_idle();
        write_reg(REG_SEARCH_LOW, {16'h0000, 16'h0044, 16'h0042, 16'h0041});
        push_subject(16'h0044, 1'b1);
        wait_idle();

        // pattern length changed while characters are pending drops them
        push_subject(16'h0041, 1'b0);
        push_subject(16'h0042, 1'b0);
        wait_idle();
        write_reg(REG_SEARCH_LEN, 64'd2);
        push_subject(16'h0043, 1'b1);
        wait_idle();

        // oversized lengths clamp to eight
        write_reg(REG_SEARCH_LEN, 64'd12);
        write_reg(REG_SEARCH_LOW, {16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5});
        write_reg(REG_SEARCH_HIGH, {16'h8000, 16'h0001, 16'h7FFF, 16'hFFFF});
        write_reg(REG_REPLACE_LEN, 64'd15);
        for (i = 0; i < 8; i++)
            push_subject(text_slot(pat_lo, pat_hi, i), 1'b0);
        push_subject(16'hFFFF, 1'b1);
        wait_idle();

        rand_items = 0;
        open_text = 1'b0;
        ph = 0;
        while (rand_items < 300)
        begin
            random_setup(ph, open_text && $urandom_range(0, 1));
            phases++;
            if (ph == 2)
                hold_go = 1'b1;
            target = (pat_len == 0) ? $urandom_range(3, 8) : $urandom_range(20, 45);
            pushed = 0;
            paused = 1'b0;
            open_text = 1'b0;
            while (pushed < target)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                finish = !(pushed + len >= target && $urandom_range(0, 2) == 0);
                queue_subject(len, finish);
                open_text = !finish;
                pushed += len;
                // sender pause halfway through random phase 4 until the unit is fully drained
                if (ph == 4 && !paused && pushed >= target / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            if (pat_len != 0)
                rand_items += pushed;
            wait_idle();
            ph++;
        end

        wait_idle();
        $display("run covered %0d subject characters in %0d random phases after the directed cases",
                 chars_in, phases);
        $display("%0d register writes, %0d output results checked", cfg_writes, results_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== stream_search_replace_unit.f =====
+incdir+rtl/core
rtl/core/ssr_pkg.sv
rtl/core/ssr_front.sv
rtl/core/ssr_cmd_fifo.sv
rtl/core/ssr_back.sv
rtl/core/stream_search_replace_unit.sv
tb/stream_search_replace_unit_tb.sv
